>>> sv/mmsr_pkg.sv
// ----------------------------------------------------------------------------
// mmsr_pkg - shared types and constants for the mecanum mixer
// Request and response formats, function codes, register indexes and the
// constants used to build the sine table.
// ----------------------------------------------------------------------------
package mmsr_pkg;

  localparam int unsigned HeadingBitsDef  = 12;
  localparam int unsigned SineFracBitsDef = 15;

  // fixed point used while building the sine table
  localparam int unsigned     WorkFrac   = 30;
  localparam longint unsigned PiHalfWork = 64'd1686629713;
  // (2n)(2n+1) for the taylor terms n = 1..8
  localparam longint unsigned TaylorDiv [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  localparam int unsigned StepW    = 7;
  localparam int unsigned LimitW   = 7;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 7;

  localparam logic [CfgIdxW-1:0] REG_MAX_STEP    = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_SPEED_LIMIT = 1'b1;

  localparam logic [StepW-1:0]  MaxStepRst    = 7'd5;
  localparam logic [LimitW-1:0] SpeedLimitRst = 7'd100;

  typedef enum logic [1:0] {
    FUNC_DIRECT  = 2'd0,
    FUNC_HEADING = 2'd1,
    FUNC_STEP    = 2'd2
  } func_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [11:0]        heading;
    logic signed [15:0] commanded_speed;
    logic signed [7:0]  target_one;
    logic signed [7:0]  target_two;
    logic signed [7:0]  target_three;
    logic signed [7:0]  target_four;
  } in_req_t;

  typedef struct packed {
    logic signed [7:0] speed_one;
    logic signed [7:0] speed_two;
    logic signed [7:0] speed_three;
    logic signed [7:0] speed_four;
    logic              reached;
  } out_rsp_t;

  // what travels down the pipe beside the mixing datapath
  typedef struct packed {
    logic [1:0]      func;
    logic [3:0][7:0] tgt;
  } item_t;

  // per-stage load enables
  typedef struct packed {
    logic a;
    logic b;
    logic c;
    logic d;
  } pipe_en_t;

endpackage

>>> sv/mmsr_sine_rom.sv
// ----------------------------------------------------------------------------
// mmsr_sine_rom - quarter-wave sine and cosine lookup
// Folds the heading into a quarter-wave index for sine and cosine and reads
// both from one constant table with registered read data.
// ----------------------------------------------------------------------------
module mmsr_sine_rom import mmsr_pkg::*; #(
  parameter int unsigned HeadingBits  = HeadingBitsDef,
  parameter int unsigned SineFracBits = SineFracBitsDef
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [HeadingBits-1:0]  heading_i,
  output logic [SineFracBits:0]   sin_mag_o,
  output logic                    sin_neg_o,
  output logic [SineFracBits:0]   cos_mag_o,
  output logic                    cos_neg_o
);

  localparam int unsigned QuarterBits = HeadingBits - 2;
  localparam int unsigned RomDepth    = (1 << QuarterBits) + 1;
  localparam int unsigned MagW        = SineFracBits + 1;
  localparam int unsigned RoundShift  = WorkFrac - SineFracBits;

  typedef logic [MagW-1:0] rom_t [RomDepth];

  function automatic rom_t build_rom();
    rom_t            rom;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    for (int k = 0; k < RomDepth; k++) begin
      x    = (PiHalfWork * longint'(k)) >> QuarterBits;
      x2   = (x * x) >> WorkFrac;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> WorkFrac) / TaylorDiv[n-1];
        if ((n % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > (64'sd1 <<< WorkFrac)) begin
        sum = 64'sd1 <<< WorkFrac;
      end
      rom[k] = MagW'((sum + (64'sd1 <<< (RoundShift - 1))) >>> RoundShift);
    end
    return rom;
  endfunction

  localparam rom_t SineRom = build_rom();

  logic [1:0]             quad;
  logic [QuarterBits-1:0] frac;
  logic [QuarterBits:0]   k_fwd;
  logic [QuarterBits:0]   k_rev;
  logic [QuarterBits:0]   k_sin;
  logic [QuarterBits:0]   k_cos;

  assign quad  = heading_i[HeadingBits-1 -: 2];
  assign frac  = heading_i[QuarterBits-1:0];
  assign k_fwd = {1'b0, frac};
  assign k_rev = (QuarterBits+1)'(1 << QuarterBits) - k_fwd;
  // cosine sits one quadrant ahead
  assign k_sin = quad[0] ? k_rev : k_fwd;
  assign k_cos = quad[0] ? k_fwd : k_rev;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_mag_o <= SineRom[k_sin];
      cos_mag_o <= SineRom[k_cos];
      sin_neg_o <= quad[1];
      cos_neg_o <= quad[1] ^ quad[0];
    end
  end

endmodule

>>> sv/mmsr_mix.sv
// ----------------------------------------------------------------------------
// mmsr_mix - heading mixer
// Scales sine and cosine by the clamped speed, then forms vy+vx and vy-vx
// rounded half away from zero and saturated to +-127.
// ----------------------------------------------------------------------------
module mmsr_mix import mmsr_pkg::*; #(
  parameter int unsigned SineFracBits = SineFracBitsDef
) (
  input  logic                   clk_i,
  input  pipe_en_t               en_i,
  input  logic [SineFracBits:0]  sin_mag_i,
  input  logic                   sin_neg_i,
  input  logic [SineFracBits:0]  cos_mag_i,
  input  logic                   cos_neg_i,
  input  logic signed [7:0]      spd_i,
  output logic signed [7:0]      plus_o,
  output logic signed [7:0]      minus_o
);

  localparam int unsigned MagW  = SineFracBits + 1;
  localparam int unsigned ProdW = MagW + 9;
  localparam int unsigned SumW  = ProdW + 1;

  function automatic logic signed [7:0] round_sat(input logic signed [SumW-1:0] v);
    logic [SumW-1:0] mag;
    logic [SumW-1:0] rnd;
    logic [7:0]      res;
    mag = v[SumW-1] ? SumW'(-v) : SumW'(v);
    rnd = (mag + (SumW'(1) << (SineFracBits - 1))) >> SineFracBits;
    res = (rnd > SumW'(127)) ? 8'd127 : rnd[7:0];
    return v[SumW-1] ? -res : res;
  endfunction

  logic signed [MagW:0]    sin_s;
  logic signed [MagW:0]    cos_s;
  logic signed [ProdW-1:0] vx_d, vx_q;
  logic signed [ProdW-1:0] vy_d, vy_q;
  logic signed [SumW-1:0]  sum_p;
  logic signed [SumW-1:0]  sum_m;

  assign sin_s = sin_neg_i ? -$signed({1'b0, sin_mag_i}) : $signed({1'b0, sin_mag_i});
  assign cos_s = cos_neg_i ? -$signed({1'b0, cos_mag_i}) : $signed({1'b0, cos_mag_i});
  assign vx_d  = sin_s * spd_i;
  assign vy_d  = cos_s * spd_i;

  always_ff @(posedge clk_i) begin
    if (en_i.b) begin
      vx_q <= vx_d;
      vy_q <= vy_d;
    end
  end

  assign sum_p = SumW'(vy_q) + SumW'(vx_q);
  assign sum_m = SumW'(vy_q) - SumW'(vx_q);

  always_ff @(posedge clk_i) begin
    if (en_i.c) begin
      plus_o  <= round_sat(sum_p);
      minus_o <= round_sat(sum_m);
    end
  end

endmodule

>>> sv/mmsr_ramp.sv
// ----------------------------------------------------------------------------
// mmsr_ramp - target selection and slew-limited ramp
// Holds the wheel targets and speeds, picks new targets per request and
// moves each speed at most max_step toward its target, clamped to the limit.
// ----------------------------------------------------------------------------
module mmsr_ramp import mmsr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  item_t              item_i,
  input  logic signed [7:0]  plus_i,
  input  logic signed [7:0]  minus_i,
  input  logic [StepW-1:0]   max_step_i,
  input  logic [LimitW-1:0]  speed_limit_i,
  output logic [3:0][7:0]    speed_o,
  output logic               reached_o
);

  logic [3:0][7:0] tgt_q, tgt_d;
  logic [3:0][7:0] spd_q, spd_d;
  logic            reached_q, reached_d;

  always_comb begin
    case (func_e'(item_i.func))
      FUNC_DIRECT:  tgt_d = item_i.tgt;
      FUNC_HEADING: tgt_d = {plus_i, minus_i, minus_i, plus_i};
      FUNC_STEP:    tgt_d = tgt_q;
      default:      tgt_d = tgt_q;
    endcase
  end

  always_comb begin
    logic signed [8:0] cur;
    logic signed [8:0] tgt;
    logic signed [8:0] diff;
    logic signed [8:0] mag;
    logic signed [8:0] stp;
    logic signed [8:0] lim;
    logic signed [8:0] nxt;
    stp       = $signed({2'b00, max_step_i});
    lim       = $signed({2'b00, speed_limit_i});
    reached_d = 1'b1;
    for (int i = 0; i < 4; i++) begin
      cur  = $signed({spd_q[i][7], spd_q[i]});
      tgt  = $signed({tgt_d[i][7], tgt_d[i]});
      diff = tgt - cur;
      mag  = diff[8] ? -diff : diff;
      nxt  = tgt;
      if (mag > stp) begin
        nxt = diff[8] ? cur - stp : cur + stp;
      end
      if (nxt > lim) begin
        nxt = lim;
      end else if (nxt < -lim) begin
        nxt = -lim;
      end
      spd_d[i] = nxt[7:0];
      if (nxt != tgt) begin
        reached_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q     <= '0;
      spd_q     <= '0;
      reached_q <= 1'b0;
    end else if (load_i) begin
      tgt_q     <= tgt_d;
      spd_q     <= spd_d;
      reached_q <= reached_d;
    end
  end

  assign speed_o   = spd_q;
  assign reached_o = reached_q;

endmodule

>>> sv/mecanum_mixer_slew_ramp.sv
// ----------------------------------------------------------------------------
// mecanum_mixer_slew_ramp - mecanum wheel mixer with slew-rate limiter
// Four-stage pipeline: sine lookup, speed scaling, mix and round, ramp step.
// ----------------------------------------------------------------------------
// Each request selects new wheel targets (direct, from heading and speed, or
// unchanged) and takes one slew-limited ramp step; one response with the
// four wheel speeds and a reached flag is presented once the request has
// passed stages a to d. A new request is accepted every cycle while not stalled;
// the wheel state lives in the last stage only, so back-to-back requests see each other's results.
// The sine table is a constant ROM of 2^(HEADING_BITS-2)+1 entries read at
// two addresses per cycle. Stages with no request collapse when the output
// is stalled, so up to four requests can be held in flight.
module mecanum_mixer_slew_ramp import mmsr_pkg::*; #(
  parameter int unsigned HEADING_BITS       = HeadingBitsDef,
  parameter int unsigned SINE_FRACTION_BITS = SineFracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_req_t             in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_rsp_t            out_rsp_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  logic [StepW-1:0]  max_step_q;
  logic [LimitW-1:0] speed_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_step_q    <= MaxStepRst;
      speed_limit_q <= SpeedLimitRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_MAX_STEP) begin
        max_step_q <= cfg_wdata_i[StepW-1:0];
      end
      if (cfg_idx_i == REG_SPEED_LIMIT) begin
        speed_limit_q <= cfg_wdata_i[LimitW-1:0];
      end
    end
  end

  // pipeline occupancy and load enables
  logic     a_vld_q, b_vld_q, c_vld_q, d_vld_q;
  pipe_en_t en;

  assign en.d = !d_vld_q || !out_stall_i;
  assign en.c = !c_vld_q || en.d;
  assign en.b = !b_vld_q || en.c;
  assign en.a = !a_vld_q || en.b;

  assign in_stall_o  = !en.a;
  assign out_valid_o = d_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else begin
      if (en.a) a_vld_q <= in_valid_i;
      if (en.b) b_vld_q <= a_vld_q;
      if (en.c) c_vld_q <= b_vld_q;
      if (en.d) d_vld_q <= c_vld_q;
    end
  end

  // stage a: clamp speed and direct targets
  function automatic logic [7:0] clamp_tgt(input logic signed [7:0] t);
    return (t == -8'sd128) ? 8'h81 : t;
  endfunction

  logic signed [15:0] lim16;
  logic signed [15:0] cmd;
  logic signed [15:0] spd16;
  item_t              item_a_d, item_a_q, item_b_q, item_c_q;
  logic signed [7:0]  spd_a_q;

  assign lim16 = $signed({9'd0, speed_limit_q});
  assign cmd   = in_req_i.commanded_speed;
  assign spd16 = (cmd > lim16) ? lim16 : ((cmd < -lim16) ? -lim16 : cmd);

  assign item_a_d.func   = in_req_i.func;
  assign item_a_d.tgt[0] = clamp_tgt(in_req_i.target_one);
  assign item_a_d.tgt[1] = clamp_tgt(in_req_i.target_two);
  assign item_a_d.tgt[2] = clamp_tgt(in_req_i.target_three);
  assign item_a_d.tgt[3] = clamp_tgt(in_req_i.target_four);

  always_ff @(posedge clk_i) begin
    if (en.a) begin
      item_a_q <= item_a_d;
      spd_a_q  <= spd16[7:0];
    end
    if (en.b) item_b_q <= item_a_q;
    if (en.c) item_c_q <= item_b_q;
  end

  logic [SINE_FRACTION_BITS:0] sin_mag, cos_mag;
  logic                        sin_neg, cos_neg;

  mmsr_sine_rom #(
    .HeadingBits  (HEADING_BITS),
    .SineFracBits (SINE_FRACTION_BITS)
  ) u_sine_rom (
    .clk_i     (clk_i),
    .en_i      (en.a),
    .heading_i (HEADING_BITS'(in_req_i.heading)),
    .sin_mag_o (sin_mag),
    .sin_neg_o (sin_neg),
    .cos_mag_o (cos_mag),
    .cos_neg_o (cos_neg)
  );

  logic signed [7:0] plus_c, minus_c;

  mmsr_mix #(
    .SineFracBits (SINE_FRACTION_BITS)
  ) u_mix (
    .clk_i     (clk_i),
    .en_i      (en),
    .sin_mag_i (sin_mag),
    .sin_neg_i (sin_neg),
    .cos_mag_i (cos_mag),
    .cos_neg_i (cos_neg),
    .spd_i     (spd_a_q),
    .plus_o    (plus_c),
    .minus_o   (minus_c)
  );

  logic [3:0][7:0] speed;
  logic            reached;

  mmsr_ramp u_ramp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (en.d && c_vld_q),
    .item_i        (item_c_q),
    .plus_i        (plus_c),
    .minus_i       (minus_c),
    .max_step_i    (max_step_q),
    .speed_limit_i (speed_limit_q),
    .speed_o       (speed),
    .reached_o     (reached)
  );

  assign out_rsp_o.speed_one   = speed[0];
  assign out_rsp_o.speed_two   = speed[1];
  assign out_rsp_o.speed_three = speed[2];
  assign out_rsp_o.speed_four  = speed[3];
  assign out_rsp_o.reached     = reached;

endmodule

>>> tb/mmsr_speed_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmsr_speed_checker - wheel speed predictor and response checker
// Watches the request, response and register ports of the mecanum mixer.
// For every request taken it works out the four wheel speeds and the reached
// flag from its own copy of the targets, speeds and registers. It compares
// every response taken against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module mmsr_speed_checker import mmsr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_req_t             in_req_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_rsp_t            out_rsp_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  checked_o
);

  localparam int unsigned HeadBits    = HeadingBitsDef;
  localparam int unsigned QuarterBits = HeadBits - 2;
  localparam int unsigned FracBits    = SineFracBitsDef;
  localparam int unsigned QuarterLen  = 1 << QuarterBits;

  longint    sine_rom [QuarterLen+1];
  int        wheel_now [4];
  int        wheel_aim [4];
  int        max_step_q;
  int        limit_q;
  out_rsp_t  speeds_q [$];
  out_rsp_t  want;
  int        err_cnt;
  int        n_checked;

  // quarter-wave sine in the block's fraction format, taylor series to x^17
  function automatic longint quarter_sine(int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    x    = (PiHalfWork * longint'(k)) >> QuarterBits;
    x2   = (x * x) >> WorkFrac;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> WorkFrac) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 <<< WorkFrac)) acc = 64'sd1 <<< WorkFrac;
    return (acc + (64'sd1 <<< (WorkFrac - FracBits - 1))) >>> (WorkFrac - FracBits);
  endfunction

  function automatic longint sine_of(logic [HeadBits-1:0] h);
    int unsigned quad;
    int unsigned rem;
    int unsigned k;
    quad = (h >> QuarterBits) & 3;
    rem  = h & (QuarterLen - 1);
    k    = (quad & 1) ? QuarterLen - rem : rem;
    return (quad & 2) ? -sine_rom[k] : sine_rom[k];
  endfunction

  function automatic int clamp_sym(int v, int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // round half away from zero, then saturate to the wheel range
  function automatic int round_mix(longint v);
    longint mag;
    longint r;
    mag = (v < 0) ? -v : v;
    r   = (mag + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
    if (v < 0) r = -r;
    return clamp_sym(int'(r), 127);
  endfunction

  function automatic out_rsp_t ramp_predict(in_req_t r);
    out_rsp_t            rsp;
    logic [HeadBits-1:0] hc;
    longint              sn;
    longint              cs;
    longint              spd;
    int                  plus;
    int                  minus;
    int                  diff;
    int                  mag;
    int                  nxt;
    logic                all_at;
    all_at = 1'b1;
    case (r.func)
      FUNC_DIRECT: begin
        wheel_aim[0] = clamp_sym(int'($signed(r.target_one)), 127);
        wheel_aim[1] = clamp_sym(int'($signed(r.target_two)), 127);
        wheel_aim[2] = clamp_sym(int'($signed(r.target_three)), 127);
        wheel_aim[3] = clamp_sym(int'($signed(r.target_four)), 127);
      end
      FUNC_HEADING: begin
        hc    = r.heading + HeadBits'(QuarterLen);
        sn    = sine_of(r.heading);
        cs    = sine_of(hc);
        spd   = clamp_sym(int'($signed(r.commanded_speed)), limit_q);
        plus  = round_mix(cs * spd + sn * spd);
        minus = round_mix(cs * spd - sn * spd);
        wheel_aim[0] = plus;
        wheel_aim[1] = minus;
        wheel_aim[2] = minus;
        wheel_aim[3] = plus;
      end
      default: ;  // step only, spare code included
    endcase
    for (int i = 0; i < 4; i++) begin
      diff = wheel_aim[i] - wheel_now[i];
      mag  = (diff < 0) ? -diff : diff;
      nxt  = wheel_aim[i];
      if (mag > max_step_q) begin
        nxt = (wheel_aim[i] > wheel_now[i]) ? wheel_now[i] + max_step_q
                                            : wheel_now[i] - max_step_q;
      end
      nxt          = clamp_sym(nxt, limit_q);
      wheel_now[i] = nxt;
      if (nxt != wheel_aim[i]) all_at = 1'b0;
    end
    rsp.speed_one   = 8'(wheel_now[0]);
    rsp.speed_two   = 8'(wheel_now[1]);
    rsp.speed_three = 8'(wheel_now[2]);
    rsp.speed_four  = 8'(wheel_now[3]);
    rsp.reached     = all_at;
    return rsp;
  endfunction

  task automatic report_field(string name, logic signed [7:0] exp_v,
                              logic signed [7:0] got_v);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
    err_cnt++;
  endtask

  initial begin
    for (int k = 0; k <= QuarterLen; k++) sine_rom[k] = quarter_sine(k);
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        wheel_now[i] = 0;
        wheel_aim[i] = 0;
      end
      max_step_q = int'(MaxStepRst);
      limit_q    = int'(SpeedLimitRst);
      speeds_q.delete();
      err_cnt    = 0;
      n_checked  = 0;
      errors_o  <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (speeds_q.size() == 0) begin
          $display("%0t: response with no request outstanding: %p", $time, out_rsp_i);
          err_cnt++;
        end else begin
          want = speeds_q.pop_front();
          n_checked++;
          if (out_rsp_i.speed_one !== want.speed_one)
            report_field("speed_one", want.speed_one, out_rsp_i.speed_one);
          if (out_rsp_i.speed_two !== want.speed_two)
            report_field("speed_two", want.speed_two, out_rsp_i.speed_two);
          if (out_rsp_i.speed_three !== want.speed_three)
            report_field("speed_three", want.speed_three, out_rsp_i.speed_three);
          if (out_rsp_i.speed_four !== want.speed_four)
            report_field("speed_four", want.speed_four, out_rsp_i.speed_four);
          if (out_rsp_i.reached !== want.reached)
            report_field("reached", {7'd0, want.reached}, {7'd0, out_rsp_i.reached});
        end
      end
      if (in_valid_i && !in_stall_i) speeds_q.push_back(ramp_predict(in_req_i));
      // registers only change while nothing is in flight
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MAX_STEP:    max_step_q = int'(cfg_wdata_i);
          REG_SPEED_LIMIT: limit_q    = int'(cfg_wdata_i);
          default: ;
        endcase
      end
      errors_o  <= err_cnt;
      pending_o <= speeds_q.size();
      checked_o <= n_checked;
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench top for the mecanum mixer with slew-rate limiter
// Drives a directed set of requests and then random request streams under a
// series of register settings and idle patterns, including a long output
// hold-off and a full drain. Checking is done by the speed checker beside
// the block; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import mmsr_pkg::*;

  localparam logic [1:0] FuncSpare = 2'd3;
  localparam int         NumPhases = 8;
  localparam int         PhaseReqs = 105;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  in_req_t             in_req      = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  out_rsp_t            out_rsp;
  logic                cfg_we      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx     = REG_MAX_STEP;
  logic [CfgDataW-1:0] cfg_wdata   = '0;
  int                  errors;
  int                  pending;
  int                  checked;

  int unsigned stall_pct = 0;
  logic        hold_go   = 1'b0;
  int unsigned idle_pct  = 0;
  int          n_sent    = 0;
  int          n_settings = 0;

  mecanum_mixer_slew_ramp i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  mmsr_speed_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_i   (out_rsp),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  // response side: random stalls, plus one long hold-off counted here
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        hold_go  <= 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic in_req_t mk(logic [1:0] f, int hd, int sp, int a, int b, int c, int d);
    in_req_t r;
    r.func            = f;
    r.heading         = 12'(hd);
    r.commanded_speed = 16'(sp);
    r.target_one      = 8'(a);
    r.target_two      = 8'(b);
    r.target_three    = 8'(c);
    r.target_four     = 8'(d);
    return r;
  endfunction

  // mostly step and heading requests so ramps run to their targets
  function automatic in_req_t rand_req(int lim);
    in_req_t     r;
    int unsigned sel;
    int          sp;
    r.heading      = 12'($urandom);
    r.target_one   = 8'($urandom);
    r.target_two   = 8'($urandom);
    r.target_three = 8'($urandom);
    r.target_four  = 8'($urandom);
    if ($urandom_range(99) < 30) begin
      sp = int'($urandom);
    end else begin
      sp = int'($urandom_range(2 * lim + 8)) - (lim + 4);
    end
    r.commanded_speed = 16'(sp);
    sel = $urandom_range(99);
    if (sel < 25)      r.func = FUNC_DIRECT;
    else if (sel < 55) r.func = FUNC_HEADING;
    else if (sel < 95) r.func = FUNC_STEP;
    else               r.func = FuncSpare;
    return r;
  endfunction

  task automatic send_req(in_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    n_sent++;
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // four-stage pipe, allow some margin
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_regs(int stp, int lim);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_MAX_STEP;
    cfg_wdata <= CfgDataW'(stp);
    @(posedge clk_i);
    cfg_idx   <= REG_SPEED_LIMIT;
    cfg_wdata <= CfgDataW'(lim);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    n_settings++;
  endtask

  initial begin
    int ph_step [NumPhases] = '{5, 127, 1, 0, 20, 7, 0, 3};
    int ph_lim  [NumPhases] = '{100, 127, 127, 60, 0, 1, 0, 127};
    int ph_mode [NumPhases] = '{0, 1, 2, 3, 0, 1, 2, 3};
    int stp;
    int lim;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed requests at the reset register values
    send_req(mk(FUNC_DIRECT, 0, 0, 127, -128, 0, -1));
    send_req(mk(FUNC_STEP, 0, 0, 0, 0, 0, 0));
    send_req(mk(FUNC_DIRECT, 4095, -1, -128, 127, 1, -127));
    send_req(mk(FUNC_HEADING, 0, 32767, 0, 0, 0, 0));
    send_req(mk(FUNC_HEADING, 1024, -32768, 0, 0, 0, 0));
    send_req(mk(FUNC_HEADING, 2048, 100, 0, 0, 0, 0));
    send_req(mk(FUNC_HEADING, 3072, -100, 0, 0, 0, 0));
    send_req(mk(FUNC_HEADING, 512, 100, 0, 0, 0, 0));      // mixed target saturates
    send_req(mk(FUNC_HEADING, 2560, -100, 0, 0, 0, 0));
    send_req(mk(FUNC_HEADING, 4095, 1, 0, 0, 0, 0));
    send_req(mk(FUNC_HEADING, 1, 0, 0, 0, 0, 0));
    send_req(mk(FUNC_HEADING, 1536, 37, 0, 0, 0, 0));
    send_req(mk(FuncSpare, 4095, -1, -1, -1, -1, -1));
    send_req(mk(FUNC_DIRECT, 0, 0, 3, -3, 0, 2));
    send_req(mk(FUNC_STEP, 0, 0, 0, 0, 0, 0));
    send_req(mk(FUNC_STEP, 0, 0, 0, 0, 0, 0));
    send_req(mk(FUNC_STEP, 0, 0, 0, 0, 0, 0));
    send_req(mk(FUNC_DIRECT, 0, 0, 0, 0, 0, 0));
    send_req(mk(FuncSpare, 0, 0, 0, 0, 0, 0));
    send_req(mk(FUNC_STEP, 0, 0, 0, 0, 0, 0));

    for (int p = 0; p < NumPhases; p++) begin
      drain_all();
      stp = ph_step[p];
      lim = ph_lim[p];
      if (p == 6) begin
        stp = $urandom_range(127, 1);
        lim = $urandom_range(127, 1);
      end
      write_regs(stp, lim);
      idle_pct   = (ph_mode[p] == 1) ? 80 : (ph_mode[p] == 3) ? 29 : 0;
      stall_pct <= (ph_mode[p] == 2) ? 80 : (ph_mode[p] == 3) ? 29 : 0;
      if (p == 0) hold_go <= 1'b1;   // output held while requests keep coming
      for (int n = 0; n < PhaseReqs; n++) begin
        if (p == 4 && n == 50) drain_all();
        send_req(rand_req(lim));
      end
    end
    drain_all();

    $display("covered %0d requests over %0d register settings, %0d responses checked,",
             n_sent, n_settings, checked);
    $display("with a long output hold-off, a mid-stream drain and mixed idle patterns");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
